>>> hw/rtl/assert_macros.svh
// Assertion helper macros for the residual unit checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hw/rtl/pger_pkg.sv
// ----------------------------------------------------------------------------
// Pose-graph edge residual package
// Shared widths and a fixed-point helper function.
// ----------------------------------------------------------------------------
package pger_pkg;
  localparam int unsigned NumRes = 6;
  localparam int unsigned NumW = 21;
  typedef logic signed [31:0] res_t;
  typedef logic signed [15:0] wgt_t;

  // Round to nearest (ties up) by 2^7 and clamp to the int32 range.
  function automatic res_t sat_round7(input logic signed [63:0] acc);
    logic signed [63:0] r;
    r = (acc + 64'sd64) >>> 7;
    if (r > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (r < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return r[31:0];
  endfunction
endpackage

>>> hw/rtl/pger_geom.sv
// ----------------------------------------------------------------------------
// Pose-graph edge residual geometry stages
// Four register stages forming the 6-vector error from the two poses and
// the measurement; advances when en_i is high.
// ----------------------------------------------------------------------------
module pger_geom (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [62:0]        ti_i,
  input  logic [63:0]        qi_i,
  input  logic [62:0]        tj_i,
  input  logic [63:0]        qj_i,
  input  logic [62:0]        tm_i,
  input  logic [63:0]        qm_i,
  output logic signed [47:0] e_o [6]
);
  // Stage 1: differences and unpacking.
  logic signed [21:0] d_q [3];
  logic signed [16:0] u_q [3];
  logic signed [15:0] w_q;
  logic signed [20:0] tm_q [3];
  logic signed [16:0] qic_q [4];
  logic signed [15:0] qj_q [4];
  logic signed [15:0] qm_q [4];
  // Stage 2: c = u x d, qr = conj(qi) * qj.
  logic signed [39:0] c_q [3];
  logic signed [21:0] d2_q [3];
  logic signed [16:0] u2_q [3];
  logic signed [15:0] w2_q;
  logic signed [20:0] tm2_q [3];
  logic signed [33:0] qr_q [4];
  logic signed [15:0] qm2_q [4];
  // Stage 3: rotated translation error, dq.
  logic signed [63:0] dt_q [3];
  logic signed [51:0] dq_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        d_q[k] <= 22'(signed'(tj_i[21*k +: 21])) - 22'(signed'(ti_i[21*k +: 21]));
        u_q[k] <= -17'(signed'(qi_i[16*k +: 16]));
        tm_q[k] <= signed'(tm_i[21*k +: 21]);
      end
      w_q <= signed'(qi_i[63:48]);
      for (int k = 0; k < 4; k++) begin
        qic_q[k] <= (k == 3) ? 17'(signed'(qi_i[16*k +: 16]))
                             : -17'(signed'(qi_i[16*k +: 16]));
        qj_q[k] <= signed'(qj_i[16*k +: 16]);
        qm_q[k] <= signed'(qm_i[16*k +: 16]);
      end
    end
  end

  // Product width sits comfortably inside the 64-bit sums used below.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q[0] <= 40'(u_q[1] * d_q[2]) - 40'(u_q[2] * d_q[1]);
      c_q[1] <= 40'(u_q[2] * d_q[0]) - 40'(u_q[0] * d_q[2]);
      c_q[2] <= 40'(u_q[0] * d_q[1]) - 40'(u_q[1] * d_q[0]);
      d2_q <= d_q;
      u2_q <= u_q;
      w2_q <= w_q;
      tm2_q <= tm_q;
      qm2_q <= qm_q;
      qr_q[0] <= 34'(qic_q[3]*qj_q[0]) + 34'(qic_q[0]*qj_q[3])
               + 34'(qic_q[1]*qj_q[2]) - 34'(qic_q[2]*qj_q[1]);
      qr_q[1] <= 34'(qic_q[3]*qj_q[1]) + 34'(qic_q[1]*qj_q[3])
               + 34'(qic_q[2]*qj_q[0]) - 34'(qic_q[0]*qj_q[2]);
      qr_q[2] <= 34'(qic_q[3]*qj_q[2]) + 34'(qic_q[2]*qj_q[3])
               + 34'(qic_q[0]*qj_q[1]) - 34'(qic_q[1]*qj_q[0]);
      qr_q[3] <= 34'(qic_q[3]*qj_q[3]) - 34'(qic_q[0]*qj_q[0])
               - 34'(qic_q[1]*qj_q[1]) - 34'(qic_q[2]*qj_q[2]);
    end
  end

  logic signed [63:0] uc [3];
  logic signed [51:0] qrc [4];
  always_comb begin
    uc[0] = 64'(u2_q[1] * c_q[2]) - 64'(u2_q[2] * c_q[1]);
    uc[1] = 64'(u2_q[2] * c_q[0]) - 64'(u2_q[0] * c_q[2]);
    uc[2] = 64'(u2_q[0] * c_q[1]) - 64'(u2_q[1] * c_q[0]);
    for (int k = 0; k < 4; k++) begin
      qrc[k] = (k == 3) ? 52'(qr_q[k]) : -52'(qr_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        dt_q[k] <= (64'(d2_q[k]) <<< 28) + 64'(w2_q * c_q[k]) * 64'sd2 + uc[k] * 64'sd2
                 - (64'(tm2_q[k]) <<< 28);
      end
      dq_q[0] <= 52'(qm2_q[3]*qrc[0]) + 52'(qm2_q[0]*qrc[3])
               + 52'(qm2_q[1]*qrc[2]) - 52'(qm2_q[2]*qrc[1]);
      dq_q[1] <= 52'(qm2_q[3]*qrc[1]) + 52'(qm2_q[1]*qrc[3])
               + 52'(qm2_q[2]*qrc[0]) - 52'(qm2_q[0]*qrc[2]);
      dq_q[2] <= 52'(qm2_q[3]*qrc[2]) + 52'(qm2_q[2]*qrc[3])
               + 52'(qm2_q[0]*qrc[1]) - 52'(qm2_q[1]*qrc[0]);
    end
  end

  // Stage 4: rounding to Q16.16.
  logic signed [63:0] tr [3];
  logic signed [51:0] rr [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tr[k] = (dt_q[k] + 64'sd2097152) >>> 22;
      rr[k] = (dq_q[k] + 52'sd16777216) >>> 25;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        e_o[k] <= tr[k][47:0];
        e_o[3+k] <= 48'(rr[k]);
      end
    end
  end
endmodule

>>> hw/rtl/pger_weight.sv
// ----------------------------------------------------------------------------
// Pose-graph edge residual weighting stages
// Two register stages: products with the lower-triangular weight, then the
// row sums with rounding and saturation.
// ----------------------------------------------------------------------------
module pger_weight (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [47:0]   e_i [6],
  input  pger_pkg::wgt_t       w_i [pger_pkg::NumW],
  output pger_pkg::res_t       r_o [pger_pkg::NumRes]
);
  logic signed [63:0] p_q [pger_pkg::NumW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 6; r++) begin
        for (int c = 0; c <= r; c++) begin
          p_q[r*(r+1)/2 + c] <= 64'(w_i[r*(r+1)/2 + c] * e_i[c]);
        end
      end
    end
  end

  logic signed [63:0] acc [6];
  always_comb begin
    for (int r = 0; r < 6; r++) begin
      acc[r] = '0;
      for (int c = 0; c <= r; c++) begin
        acc[r] = acc[r] + p_q[r*(r+1)/2 + c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 6; r++) begin
        r_o[r] <= pger_pkg::sat_round7(acc[r]);
      end
    end
  end
endmodule

>>> hw/rtl/pose_graph_edge_residual_unit.sv
// ----------------------------------------------------------------------------
// Pose-graph edge residual unit
// Weighted SE(3) residual of one pose-graph edge per beat.
// ----------------------------------------------------------------------------
// Input channel: valid_i with stall_o; one edge per beat (two poses, the
// measured relative pose and 21 weight entries). Output channel: valid_o
// with stall_i; six saturated Q16.16 residuals per beat.
// An input beat passes through seven register stages before its result is
// presented on valid_o: unpack, cross product and first quaternion product,
// rotation and second quaternion product, rounding, weight products, row
// sums, and the output register.
// Throughput is one beat per cycle unless the receiver stalls. The whole
// pipeline advances together; while the receiver stalls with a result held
// at the output, the whole pipeline freezes, bubbles included, and stall_o
// stays raised.
// Reset clears all valid bits; no result appears until an input is taken.
// ----------------------------------------------------------------------------
module pose_graph_edge_residual_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [62:0]           pose_i_translation_i,
  input  logic [63:0]           pose_i_rotation_i,
  input  logic [62:0]           pose_j_translation_i,
  input  logic [63:0]           pose_j_rotation_i,
  input  logic [62:0]           meas_translation_i,
  input  logic [63:0]           meas_rotation_i,
  input  logic [63:0]           weight_pack_0_i,
  input  logic [63:0]           weight_pack_1_i,
  input  logic [63:0]           weight_pack_2_i,
  input  logic [63:0]           weight_pack_3_i,
  input  logic [63:0]           weight_pack_4_i,
  input  logic signed [15:0]    weight_pack_5_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic signed [31:0]    residual_tx_o,
  output logic signed [31:0]    residual_ty_o,
  output logic signed [31:0]    residual_tz_o,
  output logic signed [31:0]    residual_rx_o,
  output logic signed [31:0]    residual_ry_o,
  output logic signed [31:0]    residual_rz_o
);
  localparam int unsigned Depth = 7;

  logic [Depth-1:0] vld_q;
  logic             en;

  // Advance unless the output holds an untaken result.
  assign en = !(vld_q[Depth-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  logic [255:0] wcat;
  pger_pkg::wgt_t w_in [pger_pkg::NumW];
  assign wcat = {weight_pack_3_i, weight_pack_2_i, weight_pack_1_i, weight_pack_0_i};
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      w_in[k] = signed'(wcat[16*k +: 16]);
    end
    for (int k = 0; k < 4; k++) begin
      w_in[16+k] = signed'(weight_pack_4_i[16*k +: 16]);
    end
    w_in[20] = weight_pack_5_i;
  end

  // Weights travel alongside the geometry stages.
  pger_pkg::wgt_t w_q [4][pger_pkg::NumW];
  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q[0] <= w_in;
      for (int s = 1; s < 4; s++) begin
        w_q[s] <= w_q[s-1];
      end
    end
  end

  logic signed [47:0] e [6];
  pger_geom u_geom (
    .clk_i (clk_i),
    .en_i  (en),
    .ti_i  (pose_i_translation_i),
    .qi_i  (pose_i_rotation_i),
    .tj_i  (pose_j_translation_i),
    .qj_i  (pose_j_rotation_i),
    .tm_i  (meas_translation_i),
    .qm_i  (meas_rotation_i),
    .e_o   (e)
  );

  pger_pkg::res_t r [pger_pkg::NumRes];
  pger_weight u_weight (
    .clk_i (clk_i),
    .en_i  (en),
    .e_i   (e),
    .w_i   (w_q[3]),
    .r_o   (r)
  );

  pger_pkg::res_t out_q [pger_pkg::NumRes];
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= r;
    end
  end

  assign residual_tx_o = out_q[0];
  assign residual_ty_o = out_q[1];
  assign residual_tz_o = out_q[2];
  assign residual_rx_o = out_q[3];
  assign residual_ry_o = out_q[4];
  assign residual_rz_o = out_q[5];
endmodule

>>> hw/rtl/pger_checker.sv
// ----------------------------------------------------------------------------
// Pose-graph edge residual port checker
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pger_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               valid_o,
  input logic               stall_i,
  input logic               stall_o,
  input logic signed [31:0] residual_tx_o
);
  `CHK_NEXT(a_out_hold, clk_i, rst_ni, valid_o && stall_i, valid_o, "output beat dropped")
  `CHK_NEXT(a_data_hold, clk_i, rst_ni, valid_o && stall_i, $stable(residual_tx_o), "stalled data changed")
  `CHK_IMPL(a_stall_src, clk_i, rst_ni, stall_o, valid_o && stall_i, "input stalled without cause")
endmodule

bind pose_graph_edge_residual_unit pger_checker u_pger_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_o       (valid_o),
  .stall_i       (stall_i),
  .stall_o       (stall_o),
  .residual_tx_o (residual_tx_o)
);

>>> tb/pger_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose-graph edge residual checker
// Watches both channels of the residual unit, predicts the six weighted
// residuals of every accepted edge and compares each result beat in order.
// ----------------------------------------------------------------------------
module pger_tb_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic                  stall_o,
  input  logic [62:0]           pose_i_translation_i,
  input  logic [63:0]           pose_i_rotation_i,
  input  logic [62:0]           pose_j_translation_i,
  input  logic [63:0]           pose_j_rotation_i,
  input  logic [62:0]           meas_translation_i,
  input  logic [63:0]           meas_rotation_i,
  input  logic [63:0]           weight_pack_0_i,
  input  logic [63:0]           weight_pack_1_i,
  input  logic [63:0]           weight_pack_2_i,
  input  logic [63:0]           weight_pack_3_i,
  input  logic [63:0]           weight_pack_4_i,
  input  logic signed [15:0]    weight_pack_5_i,
  input  logic                  valid_o,
  input  logic                  stall_i,
  input  logic signed [31:0]    residual_tx_o,
  input  logic signed [31:0]    residual_ty_o,
  input  logic signed [31:0]    residual_tz_o,
  input  logic signed [31:0]    residual_rx_o,
  input  logic signed [31:0]    residual_ry_o,
  input  logic signed [31:0]    residual_rz_o,
  output int                    pending_o,
  output int                    failures_o
);
  typedef logic [pger_pkg::NumRes-1:0][31:0] residual_set_t;

  localparam int DueDepth = 16;

  residual_set_t due_ring [DueDepth];
  int due_head, due_tail, due_count;
  int mismatches;

  function automatic longint round_half_up(input longint x, input int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic void hamilton(input longint a[4], input longint b[4],
                                   output longint r[4]);
    r[0] = a[3] * b[0] + a[0] * b[3] + a[1] * b[2] - a[2] * b[1];
    r[1] = a[3] * b[1] + a[1] * b[3] + a[2] * b[0] - a[0] * b[2];
    r[2] = a[3] * b[2] + a[2] * b[3] + a[0] * b[1] - a[1] * b[0];
    r[3] = a[3] * b[3] - a[0] * b[0] - a[1] * b[1] - a[2] * b[2];
  endfunction

  function automatic residual_set_t weighted_edge_residual(
    input logic [62:0] pit, input logic [63:0] piq,
    input logic [62:0] pjt, input logic [63:0] pjq,
    input logic [62:0] mt, input logic [63:0] mq,
    input logic [4:0][63:0] wp, input logic [15:0] w_last);
    longint ti[3], tj[3], tm[3], d[3], u[3], c[3], uc[3], e[6];
    longint qi[4], qj[4], qm[4], qic[4], qr[4], qrc[4], dq[4], wl[21];
    longint rot, acc, r;
    int base;
    residual_set_t res;
    for (int k = 0; k < 3; k++) begin
      ti[k] = $signed(pit[21*k +: 21]);
      tj[k] = $signed(pjt[21*k +: 21]);
      tm[k] = $signed(mt[21*k +: 21]);
    end
    for (int k = 0; k < 4; k++) begin
      qi[k] = $signed(piq[16*k +: 16]);
      qj[k] = $signed(pjq[16*k +: 16]);
      qm[k] = $signed(mq[16*k +: 16]);
    end
    for (int k = 0; k < 20; k++) wl[k] = $signed(wp[k/4][16*(k%4) +: 16]);
    wl[20] = $signed(w_last);
    for (int k = 0; k < 3; k++) begin
      d[k] = tj[k] - ti[k];
      u[k] = -qi[k];
    end
    c[0] = u[1] * d[2] - u[2] * d[1];
    c[1] = u[2] * d[0] - u[0] * d[2];
    c[2] = u[0] * d[1] - u[1] * d[0];
    uc[0] = u[1] * c[2] - u[2] * c[1];
    uc[1] = u[2] * c[0] - u[0] * c[2];
    uc[2] = u[0] * c[1] - u[1] * c[0];
    for (int k = 0; k < 3; k++) begin
      rot = d[k] * (64'sd1 <<< 28) + 2 * qi[3] * c[k] + 2 * uc[k];
      e[k] = round_half_up(rot - tm[k] * (64'sd1 <<< 28), 22);
    end
    qic[0] = -qi[0]; qic[1] = -qi[1]; qic[2] = -qi[2]; qic[3] = qi[3];
    hamilton(qic, qj, qr);
    qrc[0] = -qr[0]; qrc[1] = -qr[1]; qrc[2] = -qr[2]; qrc[3] = qr[3];
    hamilton(qm, qrc, dq);
    for (int k = 0; k < 3; k++) e[3+k] = round_half_up(dq[k], 25);
    for (int k = 0; k < pger_pkg::NumRes; k++) begin
      acc = 0;
      base = k * (k + 1) / 2;
      for (int j = 0; j <= k; j++) acc += wl[base+j] * e[j];
      r = round_half_up(acc, 7);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      res[k] = r[31:0];
    end
    return res;
  endfunction

  initial begin
    failures_o = 0;
    pending_o = 0;
    mismatches = 0;
    due_head = 0;
    due_tail = 0;
    due_count = 0;
  end

  always @(posedge clk_i) begin
    residual_set_t seen, due;
    if (rst_ni && valid_o && !stall_i) begin
      seen = {residual_rz_o, residual_ry_o, residual_rx_o,
              residual_tz_o, residual_ty_o, residual_tx_o};
      if (due_count == 0) begin
        failures_o++;
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: residual beat with none outstanding", $realtime);
      end else begin
        due = due_ring[due_head];
        due_head = (due_head + 1) % DueDepth;
        due_count--;
        for (int k = 0; k < pger_pkg::NumRes; k++) begin
          if (seen[k] !== due[k]) begin
            failures_o++;
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: residual %0d expected %0d, got %0d", $realtime, k,
                       $signed(due[k]), $signed(seen[k]));
          end
        end
      end
    end
    if (rst_ni && valid_i && !stall_o) begin
      if (due_count == DueDepth) begin
        failures_o++;
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: more edges in flight than the pipeline holds", $realtime);
      end else begin
        due_ring[due_tail] = weighted_edge_residual(
          pose_i_translation_i, pose_i_rotation_i, pose_j_translation_i,
          pose_j_rotation_i, meas_translation_i, meas_rotation_i,
          {weight_pack_4_i, weight_pack_3_i, weight_pack_2_i, weight_pack_1_i,
           weight_pack_0_i}, weight_pack_5_i);
        due_tail = (due_tail + 1) % DueDepth;
        due_count++;
      end
    end
    pending_o = due_count;
  end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose-graph edge residual testbench
// Drives directed and random edges through the residual unit with random
// gaps and receiver stalls; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module testbench;
  localparam int CycleLimit = 200000;

  logic clk_i, rst_ni, valid_i, stall_o, valid_o, stall_i;
  logic [62:0] pit, pjt, mt;
  logic [63:0] piq, pjq, mq, wp0, wp1, wp2, wp3, wp4;
  logic signed [15:0] wp5;
  logic signed [31:0] rtx, rty, rtz, rrx, rry, rrz;
  int pending, failures, cycles;
  bit calm;

  pose_graph_edge_residual_unit u_top (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .pose_i_translation_i(pit), .pose_i_rotation_i(piq),
    .pose_j_translation_i(pjt), .pose_j_rotation_i(pjq),
    .meas_translation_i(mt), .meas_rotation_i(mq),
    .weight_pack_0_i(wp0), .weight_pack_1_i(wp1), .weight_pack_2_i(wp2),
    .weight_pack_3_i(wp3), .weight_pack_4_i(wp4), .weight_pack_5_i(wp5),
    .valid_o, .stall_i,
    .residual_tx_o(rtx), .residual_ty_o(rty), .residual_tz_o(rtz),
    .residual_rx_o(rrx), .residual_ry_o(rry), .residual_rz_o(rrz)
  );

  pger_tb_checker u_checker (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .pose_i_translation_i(pit), .pose_i_rotation_i(piq),
    .pose_j_translation_i(pjt), .pose_j_rotation_i(pjq),
    .meas_translation_i(mt), .meas_rotation_i(mq),
    .weight_pack_0_i(wp0), .weight_pack_1_i(wp1), .weight_pack_2_i(wp2),
    .weight_pack_3_i(wp3), .weight_pack_4_i(wp4), .weight_pack_5_i(wp5),
    .valid_o, .stall_i,
    .residual_tx_o(rtx), .residual_ty_o(rty), .residual_tz_o(rtz),
    .residual_rx_o(rrx), .residual_ry_o(rry), .residual_rz_o(rrz),
    .pending_o(pending), .failures_o(failures)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk_i) stall_i <= calm ? 1'b0 : ($urandom_range(99) < 35);

  function automatic logic [62:0] rand_vec(input int mode);
    logic [62:0] v;
    v = 63'({$urandom, $urandom});
    if (mode != 0)
      for (int k = 0; k < 3; k++) v[21*k +: 21] = 21'($signed($urandom_range(8192)) - 4096);
    return v;
  endfunction

  function automatic logic [63:0] rand_quat(input int mode);
    logic [63:0] q;
    q = {$urandom, $urandom};
    if (mode != 0) begin
      for (int k = 0; k < 3; k++) q[16*k +: 16] = 16'($signed($urandom_range(12000)) - 6000);
      q[63:48] = $urandom_range(1) ? 16'sd16384 - 16'($urandom_range(3000))
                                   : -16'sd16384 + 16'($urandom_range(3000));
    end
    return q;
  endfunction

  function automatic logic [63:0] rand_wgt(input int mode);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if (mode != 0)
      for (int k = 0; k < 4; k++) w[16*k +: 16] = 16'($signed($urandom_range(512)) - 256);
    return w;
  endfunction

  task automatic send_edge(input logic [62:0] a, input logic [63:0] b,
                           input logic [62:0] c, input logic [63:0] d,
                           input logic [62:0] e, input logic [63:0] f,
                           input logic [63:0] w0, input logic [63:0] w1,
                           input logic [63:0] w2, input logic [63:0] w3,
                           input logic [63:0] w4, input logic [15:0] w5);
    while (!calm && $urandom_range(99) < 35) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    pit <= a; piq <= b; pjt <= c; pjq <= d; mt <= e; mq <= f;
    wp0 <= w0; wp1 <= w1; wp2 <= w2; wp3 <= w3; wp4 <= w4; wp5 <= w5;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic send_random(input int mode);
    int wm;
    wm = (mode == 2) ? 0 : mode;
    send_edge(rand_vec(mode), rand_quat(mode), rand_vec(mode), rand_quat(mode),
              rand_vec(mode), rand_quat(mode), rand_wgt(wm), rand_wgt(wm),
              rand_wgt(wm), rand_wgt(wm), rand_wgt(wm),
              wm == 0 ? 16'($urandom) : 16'($signed($urandom_range(512)) - 256));
  endtask

  localparam logic [63:0] IdQuat = {16'sd16384, 48'd0};
  localparam logic [63:0] IdWgt0 = {16'd0, 16'd128, 16'd0, 16'd128};
  localparam logic [63:0] IdWgt2 = {16'd0, 16'd0, 16'd0, 16'd0};

  initial begin
    logic [62:0] tmax, tmin;
    cycles = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    stall_i = 1'b0;
    {pit, piq, pjt, pjq, mt, mq} = '0;
    {wp0, wp1, wp2, wp3, wp4, wp5} = '0;
    tmax = {3{21'h0fffff}};
    tmin = {3{21'h100000}};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_edge('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    send_edge('0, IdQuat, tmax, IdQuat, '0, IdQuat, {4{16'h0080}}, {4{16'h0080}},
              {4{16'h0080}}, {4{16'h0080}}, {4{16'h0080}}, 16'h0080);
    send_edge(tmin, IdQuat, tmax, IdQuat, tmin, IdQuat, {4{16'h7fff}}, {4{16'h7fff}},
              {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, 16'h7fff);
    send_edge(tmax, IdQuat, tmin, IdQuat, tmax, IdQuat, {4{16'h8000}}, {4{16'h8000}},
              {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 16'h8000);
    send_edge('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
    send_edge(tmax, {4{16'h7fff}}, tmin, {4{16'h8000}}, tmax, {4{16'h8000}},
              {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}},
              {4{16'h7fff}}, 16'h7fff);
    send_edge(tmin, {4{16'h8000}}, tmax, {4{16'h7fff}}, tmin, {4{16'h7fff}},
              {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
              {4{16'h8000}}, 16'h8000);
    send_edge({21'd1024, 21'd2048, 21'd3072}, {16'd11585, 16'd0, 16'd0, 16'd11585},
              {21'd5000, 21'h1ff000, 21'd7}, {16'd16384, 48'd0}, {21'd9, 21'd8, 21'd7},
              {16'd8192, 16'd100, 16'h8000, 16'd8192}, IdWgt0, {16'd0, 16'd0, 16'd128,
              16'd0}, IdWgt2, {16'd0, 16'd0, 16'd0, 16'd128}, {16'd0, 16'd0, 16'd0,
              16'd0}, 16'd128);
    for (int k = 0; k < 8; k++) send_random(k % 3);
    drain();

    for (int n = 0; n < 1430; n++) begin
      calm = (n >= 500 && n < 700);
      if (n == 900) drain();
      send_random($urandom_range(99) < 60 ? 1 : $urandom_range(2));
    end
    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
